### hw/rtl/svpwm_pkg.sv
// Shared widths, codes, reset values and types for the SVPWM compare calculator.
package svpwm_pkg;

	localparam int VOLT_W = 16;
	localparam int CNT_W  = 16;
	localparam int UDC_W  = 16;
	localparam int TIME_W = 32;
	localparam int TF     = TIME_W - CNT_W;
	localparam int MAG_W  = 35;
	localparam int NUM_W  = MAG_W + CNT_W;
	localparam int DEN1_W = UDC_W + 1;
	localparam int SUM_W  = NUM_W + 1;
	localparam int NRM_W  = 31;
	localparam int PRD_W  = NRM_W + CNT_W;

	localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;

	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;
	localparam logic [2:0] SEC_6 = 3'd6;

	localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] REG_DC_BUS      = 2'd1;
	localparam logic [1:0] REG_CMP_MAX     = 2'd2;
	localparam logic [1:0] REG_CMP_MIN     = 2'd3;

	localparam logic [CNT_W-1:0] RST_HALF_PERIOD = 16'd6000;
	localparam logic [UDC_W-1:0] RST_DC_BUS      = 16'd7168;
	localparam logic [CNT_W-1:0] RST_CMP_MAX     = 16'd5999;
	localparam logic [CNT_W-1:0] RST_CMP_MIN     = 16'd1;

	typedef struct packed {
		logic [CNT_W-1:0] half_period;
		logic [UDC_W-1:0] dc_bus;
		logic [CNT_W-1:0] cmp_max;
		logic [CNT_W-1:0] cmp_min;
	} cfg_t;

	// neg: sign of the X, Y, Z numerators, bit 0 = X
	typedef struct packed {
		logic [2:0] sector;
		logic [2:0] neg;
	} div1_sb_t;

	typedef struct packed {
		logic [2:0]        sector;
		logic              resc;
		logic [TIME_W-1:0] t1;
		logic [TIME_W-1:0] t2;
	} div2_sb_t;

endpackage

### hw/rtl/svpwm_div.sv
// Pipelined restoring divider, one quotient bit per stage, shared sideband.
module svpwm_div #(
	parameter int LANES = 1,
	parameter int DEN_W = 17,
	parameter int Q_W   = 51,
	parameter int SB_W  = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_vld,
	input  logic [DEN_W-1:0]                in_den,
	input  logic [LANES-1:0][DEN_W-1:0]     in_rem,
	input  logic [LANES-1:0][Q_W-1:0]       in_num,
	input  logic [SB_W-1:0]                 in_sb,
	output logic                            out_vld,
	output logic [LANES-1:0][Q_W-1:0]       out_quo,
	output logic [SB_W-1:0]                 out_sb
);

	logic                        vld_s [Q_W];
	logic [DEN_W-1:0]            den_s [Q_W];
	logic [LANES-1:0][DEN_W-1:0] rem_s [Q_W];
	logic [LANES-1:0][Q_W-1:0]   num_s [Q_W];
	logic [SB_W-1:0]             sb_s  [Q_W];

	genvar k, l;
	generate
		for (k = 0; k < Q_W; k++) begin : g_stage
			logic                        prv_vld;
			logic [DEN_W-1:0]            prv_den;
			logic [LANES-1:0][DEN_W-1:0] prv_rem;
			logic [LANES-1:0][Q_W-1:0]   prv_num;
			logic [SB_W-1:0]             prv_sb;
			logic [LANES-1:0][DEN_W-1:0] rem_nx;
			logic [LANES-1:0][Q_W-1:0]   num_nx;

			if (k == 0) begin : g_first
				assign prv_vld = in_vld;
				assign prv_den = in_den;
				assign prv_rem = in_rem;
				assign prv_num = in_num;
				assign prv_sb  = in_sb;
			end else begin : g_next
				assign prv_vld = vld_s[k-1];
				assign prv_den = den_s[k-1];
				assign prv_rem = rem_s[k-1];
				assign prv_num = num_s[k-1];
				assign prv_sb  = sb_s[k-1];
			end

			for (l = 0; l < LANES; l++) begin : g_lane
				logic [DEN_W:0] trial;
				logic [DEN_W:0] diff;
				logic           ge;
				assign trial = {prv_rem[l], prv_num[l][Q_W-1]};
				assign ge    = trial >= {1'b0, prv_den};
				assign diff  = trial - {1'b0, prv_den};
				assign rem_nx[l] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				assign num_nx[l] = {prv_num[l][Q_W-2:0], ge};
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= prv_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k] <= prv_den;
					rem_s[k] <= rem_nx;
					num_s[k] <= num_nx;
					sb_s[k]  <= prv_sb;
				end
			end
		end
	endgenerate

	assign out_vld = vld_s[Q_W-1];
	assign out_quo = num_s[Q_W-1];
	assign out_sb  = sb_s[Q_W-1];

endmodule

### hw/rtl/svpwm_proj.sv
// Front end: phase projections, sector code and scaled X/Y/Z numerators.
module svpwm_proj (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_vld,
	input  logic signed [svpwm_pkg::VOLT_W-1:0]   volt_alpha,
	input  logic signed [svpwm_pkg::VOLT_W-1:0]   volt_beta,
	input  logic [svpwm_pkg::CNT_W-1:0]           half_period,
	output logic                                  out_vld,
	output logic [2:0][svpwm_pkg::NUM_W-1:0]      out_num,
	output svpwm_pkg::div1_sb_t                   out_sb
);

	localparam int PRD1_W = 34;
	localparam int PRJ_W  = svpwm_pkg::MAG_W + 1;
	localparam int LO_W   = 18;
	localparam int HI_W   = svpwm_pkg::MAG_W - LO_W;

	// stage 1: products
	logic signed [PRD1_W-1:0] sa_c, sb_c, a3_c;
	logic signed [31:0]       al_sh;

	assign al_sh = signed'({volt_alpha, 16'h0000});
	assign sa_c  = svpwm_pkg::SQRT3_Q16 * volt_alpha;
	assign sb_c  = svpwm_pkg::SQRT3_Q16 * volt_beta;
	assign a3_c  = PRD1_W'(al_sh) + (PRD1_W'(al_sh) <<< 1);

	logic                          vld_s1;
	logic signed [PRD1_W-1:0]      sa_s1, sb_s1, a3_s1;
	logic signed [svpwm_pkg::VOLT_W-1:0] be_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s1 <= sa_c;
			sb_s1 <= sb_c;
			a3_s1 <= a3_c;
			be_s1 <= volt_beta;
		end
	end

	// stage 2: X/Y/Z numerators, sector
	function automatic logic [svpwm_pkg::MAG_W-1:0] mag_of(input logic signed [PRJ_W-1:0] v);
		mag_of = v[PRJ_W-1] ? svpwm_pkg::MAG_W'(-v) : svpwm_pkg::MAG_W'(v);
	endfunction

	logic signed [PRJ_W-1:0] ax_c, ay_c, az_c, be_sh, pb_c, pc_c;
	logic                    ba_c, bb_c, bc_c;
	logic [2:0]              code_c, sec_c;

	always_comb begin
		ax_c   = PRJ_W'(sb_s1) <<< 1;
		ay_c   = PRJ_W'(sb_s1) + PRJ_W'(a3_s1);
		az_c   = PRJ_W'(sb_s1) - PRJ_W'(a3_s1);
		be_sh  = PRJ_W'(signed'({be_s1, 16'h0000}));
		pb_c   = -PRJ_W'(sa_s1) - be_sh;
		pc_c   = PRJ_W'(sa_s1) - be_sh;
		ba_c   = be_s1 > 16'sd0;
		bb_c   = !pb_c[PRJ_W-1] && (pb_c != '0);
		bc_c   = !pc_c[PRJ_W-1] && (pc_c != '0);
		code_c = {ba_c, bb_c, bc_c};
		sec_c  = (code_c == 3'b000 || code_c == 3'b111) ? svpwm_pkg::SEC_1 : code_c;
	end

	logic                                  vld_s2;
	logic [2:0][svpwm_pkg::MAG_W-1:0]      mag_s2;
	svpwm_pkg::div1_sb_t                   sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2[0]     <= mag_of(ax_c);
			mag_s2[1]     <= mag_of(ay_c);
			mag_s2[2]     <= mag_of(az_c);
			sb_s2.neg     <= {az_c[PRJ_W-1], ay_c[PRJ_W-1], ax_c[PRJ_W-1]};
			sb_s2.sector  <= sec_c;
		end
	end

	// stage 3: partial products by half period
	logic                                          vld_s3;
	logic [2:0][LO_W+svpwm_pkg::CNT_W-1:0]         lo_s3;
	logic [2:0][HI_W+svpwm_pkg::CNT_W-1:0]         hi_s3;
	svpwm_pkg::div1_sb_t                           sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				lo_s3[i] <= (LO_W+svpwm_pkg::CNT_W)'(mag_s2[i][LO_W-1:0]) *
					(LO_W+svpwm_pkg::CNT_W)'(half_period);
				hi_s3[i] <= (HI_W+svpwm_pkg::CNT_W)'(mag_s2[i][svpwm_pkg::MAG_W-1:LO_W]) *
					(HI_W+svpwm_pkg::CNT_W)'(half_period);
			end
			sb_s3 <= sb_s2;
		end
	end

	// stage 4: combine partials
	logic                                  vld_s4;
	logic [2:0][svpwm_pkg::NUM_W-1:0]      num_s4;
	svpwm_pkg::div1_sb_t                   sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s4[i] <= (svpwm_pkg::NUM_W'(hi_s3[i]) << LO_W) + svpwm_pkg::NUM_W'(lo_s3[i]);
			end
			sb_s4 <= sb_s3;
		end
	end

	assign out_vld = vld_s4;
	assign out_num = num_s4;
	assign out_sb  = sb_s4;

endmodule

### hw/rtl/svpwm_norm.sv
// Active-time select, overmodulation check, sum normalize and rescale products.
module svpwm_norm (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_vld,
	input  logic [2:0][svpwm_pkg::NUM_W-1:0]      in_quo,
	input  svpwm_pkg::div1_sb_t                   in_sb,
	input  logic [svpwm_pkg::CNT_W-1:0]           half_period,
	output logic                                  out_vld,
	output logic [svpwm_pkg::NRM_W-1:0]           out_den,
	output logic [1:0][svpwm_pkg::NRM_W-1:0]      out_rem,
	output logic [1:0][svpwm_pkg::TIME_W-1:0]     out_num,
	output svpwm_pkg::div2_sb_t                   out_sb
);

	localparam int NUM_W = svpwm_pkg::NUM_W;
	localparam int SUM_W = svpwm_pkg::SUM_W;
	localparam int NRM_W = svpwm_pkg::NRM_W;
	localparam int CNT_W = svpwm_pkg::CNT_W;

	// stage 1: pick T1/T2, negative times clamp to zero
	logic [2:0][NUM_W-1:0] pos_c, neg_c;
	logic [NUM_W-1:0]      t1_c, t2_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pos_c[i] = in_sb.neg[i] ? '0 : in_quo[i];
			neg_c[i] = in_sb.neg[i] ? in_quo[i] : '0;
		end
		unique case (in_sb.sector)
			svpwm_pkg::SEC_2: begin t1_c = neg_c[0]; t2_c = pos_c[2]; end
			svpwm_pkg::SEC_3: begin t1_c = neg_c[1]; t2_c = neg_c[2]; end
			svpwm_pkg::SEC_4: begin t1_c = pos_c[2]; t2_c = pos_c[1]; end
			svpwm_pkg::SEC_5: begin t1_c = neg_c[2]; t2_c = pos_c[0]; end
			svpwm_pkg::SEC_6: begin t1_c = pos_c[0]; t2_c = neg_c[1]; end
			default:          begin t1_c = pos_c[1]; t2_c = neg_c[0]; end
		endcase
	end

	logic             vld_s1;
	logic [NUM_W-1:0] t1_s1, t2_s1;
	logic [2:0]       sec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s1  <= t1_c;
			t2_s1  <= t2_c;
			sec_s1 <= in_sb.sector;
		end
	end

	// stage 2: sum and overmodulation flag
	logic [svpwm_pkg::TIME_W-1:0] hq;
	logic [SUM_W-1:0]             sum_c;

	assign hq    = {half_period, {svpwm_pkg::TF{1'b0}}};
	assign sum_c = SUM_W'(t1_s1) + SUM_W'(t2_s1);

	logic             vld_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [NUM_W-1:0] t1_s2, t2_s2;
	logic [2:0]       sec_s2;
	logic             resc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= sum_c;
			t1_s2   <= t1_s1;
			t2_s2   <= t2_s1;
			sec_s2  <= sec_s1;
			resc_s2 <= sum_c > SUM_W'(hq);
		end
	end

	// stage 3: coarse normalize (16, 8)
	logic [SUM_W-1:0] s3_c;
	logic [NUM_W-1:0] u1_3c, u2_3c;

	always_comb begin
		s3_c  = sum_s2;
		u1_3c = t1_s2;
		u2_3c = t2_s2;
		if (|s3_c[SUM_W-1:NRM_W+15]) begin
			s3_c  = s3_c >> 16;
			u1_3c = u1_3c >> 16;
			u2_3c = u2_3c >> 16;
		end
		if (|s3_c[SUM_W-1:NRM_W+7]) begin
			s3_c  = s3_c >> 8;
			u1_3c = u1_3c >> 8;
			u2_3c = u2_3c >> 8;
		end
	end

	logic                vld_s3;
	logic [SUM_W-1:0]    sum_s3;
	logic [NUM_W-1:0]    u1_s3, u2_s3;
	svpwm_pkg::div2_sb_t sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3       <= s3_c;
			u1_s3        <= u1_3c;
			u2_s3        <= u2_3c;
			sb_s3.sector <= sec_s2;
			sb_s3.resc   <= resc_s2;
			sb_s3.t1     <= t1_s2[svpwm_pkg::TIME_W-1:0];
			sb_s3.t2     <= t2_s2[svpwm_pkg::TIME_W-1:0];
		end
	end

	// stage 4: fine normalize (4, 2, 1), sum ends below 2^NRM_W
	logic [SUM_W-1:0] s4_c;
	logic [NUM_W-1:0] u1_4c, u2_4c;

	always_comb begin
		s4_c  = sum_s3;
		u1_4c = u1_s3;
		u2_4c = u2_s3;
		if (|s4_c[SUM_W-1:NRM_W+3]) begin
			s4_c  = s4_c >> 4;
			u1_4c = u1_4c >> 4;
			u2_4c = u2_4c >> 4;
		end
		if (|s4_c[SUM_W-1:NRM_W+1]) begin
			s4_c  = s4_c >> 2;
			u1_4c = u1_4c >> 2;
			u2_4c = u2_4c >> 2;
		end
		if (|s4_c[SUM_W-1:NRM_W]) begin
			s4_c  = s4_c >> 1;
			u1_4c = u1_4c >> 1;
			u2_4c = u2_4c >> 1;
		end
	end

	logic                vld_s4;
	logic [NRM_W-1:0]    sum_s4, u1_s4, u2_s4;
	svpwm_pkg::div2_sb_t sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= s4_c[NRM_W-1:0];
			u1_s4  <= u1_4c[NRM_W-1:0];
			u2_s4  <= u2_4c[NRM_W-1:0];
			sb_s4  <= sb_s3;
		end
	end

	// stage 5: Ti * H
	logic                         vld_s5;
	logic [NRM_W-1:0]             sum_s5;
	logic [svpwm_pkg::PRD_W-1:0]  p1_s5, p2_s5;
	svpwm_pkg::div2_sb_t          sb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= sum_s4;
			p1_s5  <= svpwm_pkg::PRD_W'(u1_s4) * svpwm_pkg::PRD_W'(half_period);
			p2_s5  <= svpwm_pkg::PRD_W'(u2_s4) * svpwm_pkg::PRD_W'(half_period);
			sb_s5  <= sb_s4;
		end
	end

	// dividend is P * 2^TF: high part seeds the remainder
	assign out_vld    = vld_s5;
	assign out_den    = sum_s5;
	assign out_rem[0] = p1_s5[svpwm_pkg::PRD_W-1:CNT_W];
	assign out_rem[1] = p2_s5[svpwm_pkg::PRD_W-1:CNT_W];
	assign out_num[0] = {p1_s5[CNT_W-1:0], {svpwm_pkg::TF{1'b0}}};
	assign out_num[1] = {p2_s5[CNT_W-1:0], {svpwm_pkg::TF{1'b0}}};
	assign out_sb     = sb_s5;

endmodule

### hw/rtl/svpwm_cmp.sv
// Back end: zero time, per-sector ordering, saturation and output register.
module svpwm_cmp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_vld,
	input  logic [1:0][svpwm_pkg::TIME_W-1:0]     in_quo,
	input  svpwm_pkg::div2_sb_t                   in_sb,
	input  svpwm_pkg::cfg_t                       cfg,
	output logic                                  out_vld,
	output logic [svpwm_pkg::CNT_W-1:0]           compare_a,
	output logic [svpwm_pkg::CNT_W-1:0]           compare_b,
	output logic [svpwm_pkg::CNT_W-1:0]           compare_c,
	output logic [2:0]                            sector
);

	localparam int TIME_W = svpwm_pkg::TIME_W;
	localparam int CNT_W  = svpwm_pkg::CNT_W;
	localparam int TF     = svpwm_pkg::TF;

	// stage 1: final T1/T2 and zero time
	logic [TIME_W-1:0] hq, t1_c, t2_c, tz_c;

	always_comb begin
		hq   = {cfg.half_period, {TF{1'b0}}};
		t1_c = in_sb.resc ? in_quo[0] : in_sb.t1;
		t2_c = in_sb.resc ? in_quo[1] : in_sb.t2;
		tz_c = hq - t1_c - t2_c;
	end

	logic              vld_s1;
	logic [TIME_W-1:0] t0_s1, t1_s1, t2_s1;
	logic [2:0]        sec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s1  <= tz_c >> 1;
			t1_s1  <= t1_c;
			t2_s1  <= t2_c;
			sec_s1 <= in_sb.sector;
		end
	end

	// stage 2: cumulative edges, to counts
	logic [TIME_W-1:0] e1_c, e2_c;

	assign e1_c = t0_s1 + t1_s1;
	assign e2_c = e1_c + t2_s1;

	logic             vld_s2;
	logic [CNT_W-1:0] c0_s2, c1_s2, c2_s2;
	logic [2:0]       sec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c0_s2  <= t0_s1[TIME_W-1:TF];
			c1_s2  <= e1_c[TIME_W-1:TF];
			c2_s2  <= e2_c[TIME_W-1:TF];
			sec_s2 <= sec_s1;
		end
	end

	// stage 3: saturate, order per sector
	function automatic logic [CNT_W-1:0] sat(input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] hi, input logic [CNT_W-1:0] lo);
		priority if (v > hi) sat = hi;
		else if (v < lo)     sat = lo;
		else                 sat = v;
	endfunction

	logic [CNT_W-1:0] s0_c, s1_c, s2_c, a_c, b_c, c_c;

	always_comb begin
		s0_c = sat(c0_s2, cfg.cmp_max, cfg.cmp_min);
		s1_c = sat(c1_s2, cfg.cmp_max, cfg.cmp_min);
		s2_c = sat(c2_s2, cfg.cmp_max, cfg.cmp_min);
		unique case (sec_s2)
			svpwm_pkg::SEC_2: begin a_c = s2_c; b_c = s1_c; c_c = s0_c; end
			svpwm_pkg::SEC_3: begin a_c = s1_c; b_c = s2_c; c_c = s0_c; end
			svpwm_pkg::SEC_4: begin a_c = s1_c; b_c = s0_c; c_c = s2_c; end
			svpwm_pkg::SEC_5: begin a_c = s0_c; b_c = s1_c; c_c = s2_c; end
			svpwm_pkg::SEC_6: begin a_c = s2_c; b_c = s0_c; c_c = s1_c; end
			default:          begin a_c = s0_c; b_c = s2_c; c_c = s1_c; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			compare_a <= a_c;
			compare_b <= b_c;
			compare_c <= c_c;
			sector    <= sec_s2;
		end
	end

endmodule

### hw/rtl/svpwm_compare_calc_top.sv
// Top level of the seven-segment SVPWM compare calculator.
// Takes one alpha/beta voltage item per cycle while in_ready is high and returns the three
// phase compare counts and the sector through 4 front-end stages, a 51-stage divider for
// X/Y/Z, 5 select/normalize stages, a 32-stage divider for the overmodulation
// rescale and 3 output stages. The whole pipeline advances together whenever the
// output register is empty or being taken, so in_ready is out_ready or an empty
// output register. Configuration registers are written through the cfg port with
// cfg_ready always high; they must only change while the pipeline holds no item.
module svpwm_compare_calc_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_index,
	input  logic [15:0]                           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [svpwm_pkg::VOLT_W-1:0]   volt_alpha,
	input  logic signed [svpwm_pkg::VOLT_W-1:0]   volt_beta,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [svpwm_pkg::CNT_W-1:0]           compare_a,
	output logic [svpwm_pkg::CNT_W-1:0]           compare_b,
	output logic [svpwm_pkg::CNT_W-1:0]           compare_c,
	output logic [2:0]                            sector
);

	svpwm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= svpwm_pkg::RST_HALF_PERIOD;
			cfg_q.dc_bus      <= svpwm_pkg::RST_DC_BUS;
			cfg_q.cmp_max     <= svpwm_pkg::RST_CMP_MAX;
			cfg_q.cmp_min     <= svpwm_pkg::RST_CMP_MIN;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				svpwm_pkg::REG_HALF_PERIOD: cfg_q.half_period <= cfg_data;
				svpwm_pkg::REG_DC_BUS:      cfg_q.dc_bus      <= cfg_data;
				svpwm_pkg::REG_CMP_MAX:     cfg_q.cmp_max     <= cfg_data;
				svpwm_pkg::REG_CMP_MIN:     cfg_q.cmp_min     <= cfg_data;
			endcase
		end
	end

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// zero bus voltage counts as one
	logic [svpwm_pkg::DEN1_W-1:0] den1;
	assign den1 = {((cfg_q.dc_bus == '0) ? svpwm_pkg::UDC_W'(1) : cfg_q.dc_bus), 1'b0};

	logic                                  p_vld;
	logic [2:0][svpwm_pkg::NUM_W-1:0]      p_num;
	svpwm_pkg::div1_sb_t                   p_sb;

	svpwm_proj u_proj (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_vld      (in_valid),
		.volt_alpha  (volt_alpha),
		.volt_beta   (volt_beta),
		.half_period (cfg_q.half_period),
		.out_vld     (p_vld),
		.out_num     (p_num),
		.out_sb      (p_sb)
	);

	logic                                  d1_vld;
	logic [2:0][svpwm_pkg::NUM_W-1:0]      d1_quo;
	svpwm_pkg::div1_sb_t                   d1_sb;

	svpwm_div #(
		.LANES (3),
		.DEN_W (svpwm_pkg::DEN1_W),
		.Q_W   (svpwm_pkg::NUM_W),
		.SB_W  ($bits(svpwm_pkg::div1_sb_t))
	) u_div_xyz (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (p_vld),
		.in_den  (den1),
		.in_rem  ('0),
		.in_num  (p_num),
		.in_sb   (p_sb),
		.out_vld (d1_vld),
		.out_quo (d1_quo),
		.out_sb  (d1_sb)
	);

	logic                                  n_vld;
	logic [svpwm_pkg::NRM_W-1:0]           n_den;
	logic [1:0][svpwm_pkg::NRM_W-1:0]      n_rem;
	logic [1:0][svpwm_pkg::TIME_W-1:0]     n_num;
	svpwm_pkg::div2_sb_t                   n_sb;

	svpwm_norm u_norm (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_vld      (d1_vld),
		.in_quo      (d1_quo),
		.in_sb       (d1_sb),
		.half_period (cfg_q.half_period),
		.out_vld     (n_vld),
		.out_den     (n_den),
		.out_rem     (n_rem),
		.out_num     (n_num),
		.out_sb      (n_sb)
	);

	logic                                  d2_vld;
	logic [1:0][svpwm_pkg::TIME_W-1:0]     d2_quo;
	svpwm_pkg::div2_sb_t                   d2_sb;

	svpwm_div #(
		.LANES (2),
		.DEN_W (svpwm_pkg::NRM_W),
		.Q_W   (svpwm_pkg::TIME_W),
		.SB_W  ($bits(svpwm_pkg::div2_sb_t))
	) u_div_resc (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (n_vld),
		.in_den  (n_den),
		.in_rem  (n_rem),
		.in_num  (n_num),
		.in_sb   (n_sb),
		.out_vld (d2_vld),
		.out_quo (d2_quo),
		.out_sb  (d2_sb)
	);

	svpwm_cmp u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_vld    (d2_vld),
		.in_quo    (d2_quo),
		.in_sb     (d2_sb),
		.cfg       (cfg_q),
		.out_vld   (out_valid),
		.compare_a (compare_a),
		.compare_b (compare_b),
		.compare_c (compare_c),
		.sector    (sector)
	);

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sector >= svpwm_pkg::SEC_1 && sector <= svpwm_pkg::SEC_6))
		else $error("sector out of range");

	a_sat_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cfg_q.cmp_min <= cfg_q.cmp_max) |->
		(compare_a >= cfg_q.cmp_min && compare_a <= cfg_q.cmp_max &&
		 compare_b >= cfg_q.cmp_min && compare_b <= cfg_q.cmp_max &&
		 compare_c >= cfg_q.cmp_min && compare_c <= cfg_q.cmp_max))
		else $error("compare outside saturation window");

	a_order_sec1: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sector == svpwm_pkg::SEC_1 && cfg_q.cmp_min <= cfg_q.cmp_max) |->
		(compare_a <= compare_c && compare_c <= compare_b))
		else $error("sector 1 compare order broken");

	a_order_sec4: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sector == svpwm_pkg::SEC_4 && cfg_q.cmp_min <= cfg_q.cmp_max) |->
		(compare_b <= compare_a && compare_a <= compare_c))
		else $error("sector 4 compare order broken");

endmodule
